// ===== design/asfg_pkg.sv =====
// Shared types and constants for the PCM sample format / gain converter.
// No dependencies; every other file of the block imports this package.
package asfg_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W   = 32;   // raw and converted sample width
  localparam int FMT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GW         = 21;   // volume register width, signed
  localparam int XFRAC      = 30;   // fraction bits of the decoded level
  localparam int XW         = 35;   // decoded level, signed, up to +-8
  localparam int PW         = XW + GW;
  localparam int S16_SH     = 16;   // integer gain shift on the s16 to s16 path
  localparam int STAGES     = 5;

  localparam logic [FMT_W-1:0] FMT_F32 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FMT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd2;

  typedef struct packed {
    logic [FMT_W-1:0]    src_fmt;
    logic [FMT_W-1:0]    out_fmt;
    logic signed [GW-1:0] gain;     // Q4.frac volume as written
    logic signed [GW-1:0] gain16;   // clamped to +-1, scaled to 16 fraction bits
    logic                s16_path;  // s16 in and s16 out
  } asfg_cfg_t;

endpackage

// ===== design/asfg_ifs.sv =====
// Channel interfaces: sample in, sample out and the configuration write port.
// Depends on asfg_pkg.
interface asfg_in_if;
  import asfg_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface asfg_out_if;
  import asfg_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] converted_sample;
  modport source (output valid, output converted_sample, input ready);
  modport sink   (input valid, input converted_sample, output ready);
endinterface

interface asfg_cfg_if;
  import asfg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/asfg_cfg_regs.sv =====
// Configuration registers (formats, volume) and the derived gain with 16 fraction bits for the s16 path.
// Depends on asfg_pkg and asfg_cfg_if.
module asfg_cfg_regs #(
  parameter int GAIN_FRAC_BITS = asfg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  asfg_cfg_if.sink              cfg_if,
  output asfg_pkg::asfg_cfg_t   cfg_o
);
  import asfg_pkg::*;

  localparam int GEW  = ((GAIN_FRAC_BITS + 2) > GW) ? (GAIN_FRAC_BITS + 2) : GW;
  localparam int SH_R = (GAIN_FRAC_BITS >= 16) ? (GAIN_FRAC_BITS - 16) : 0;
  localparam int SH_L = (GAIN_FRAC_BITS < 16) ? (16 - GAIN_FRAC_BITS) : 0;
  localparam logic signed [GEW-1:0] UNITY = GEW'(64'sd1 <<< GAIN_FRAC_BITS);

  logic [FMT_W-1:0]     src_r, src_nxt;
  logic [FMT_W-1:0]     out_r, out_nxt;
  logic signed [GW-1:0] gain_r, gain_nxt;

  logic signed [GEW-1:0] ge, gc;
  logic [GEW-1:0]        mag, msc;
  logic signed [17:0]    v16;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    src_nxt  = src_r;
    out_nxt  = out_r;
    gain_nxt = gain_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_SRC_FMT: src_nxt  = cfg_if.data[FMT_W-1:0];
        REG_OUT_FMT: out_nxt  = cfg_if.data[FMT_W-1:0];
        REG_GAIN:    gain_nxt = cfg_if.data[GW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= FMT_S16;
      out_r  <= FMT_S16;
      gain_r <= GW'(65536);
    end else begin
      src_r  <= src_nxt;
      out_r  <= out_nxt;
      gain_r <= gain_nxt;
    end
  end

  // clamp the volume to +-1, then rescale to 16 fraction bits toward zero
  always_comb begin
    ge = GEW'(gain_r);
    if (ge > UNITY) begin
      gc = UNITY;
    end else if (ge < -UNITY) begin
      gc = -UNITY;
    end else begin
      gc = ge;
    end
    mag = gc[GEW-1] ? GEW'(-gc) : GEW'(gc);
    msc = (mag >> SH_R) << SH_L;
    v16 = gc[GEW-1] ? -$signed(msc[17:0]) : $signed(msc[17:0]);
  end

  always_comb begin
    cfg_o.src_fmt  = src_r;
    cfg_o.out_fmt  = out_r;
    cfg_o.gain     = gain_r;
    cfg_o.gain16   = GW'(v16);
    cfg_o.s16_path = (src_r == FMT_S16) && (out_r == FMT_S16);
  end

endmodule

// ===== design/asfg_front.sv =====
// Front stages: decode the source sample to a Q4.30 level, or keep the raw s16 integer on
// the s16 to s16 path, then multiply by the volume. Depends on asfg_pkg.
module asfg_front (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic [asfg_pkg::SAMPLE_W-1:0] raw_sample,
  input  asfg_pkg::asfg_cfg_t           cfg,
  output logic signed [asfg_pkg::PW-1:0] prod
);
  import asfg_pkg::*;

  logic [7:0]           e;
  logic [22:0]          f;
  logic [23:0]          m;
  logic [7:0]           shl, shr;
  logic [XW-2:0]        fmag;
  logic signed [XW-1:0] x;

  logic signed [XW-1:0] a_r, a_nxt;
  logic signed [GW-1:0] b_r, b_nxt;
  logic signed [PW-1:0] p_r, p_nxt;

  // float decode: NaN to zero, saturate at +-8, truncate below 2^-30
  always_comb begin
    e   = raw_sample[30:23];
    f   = raw_sample[22:0];
    m   = {(e != 8'd0), f};
    shl = e - 8'd120;
    shr = 8'd120 - e;
    if (e == 8'hFF && f != 23'd0) begin
      fmag = '0;
    end else if (e >= 8'd130) begin
      fmag = (XW-1)'(1) << (XFRAC + 3);
    end else if (e >= 8'd120) begin
      fmag = (XW-1)'(m) << shl[3:0];
    end else if (shr >= 8'd32) begin
      fmag = '0;
    end else begin
      fmag = (XW-1)'(m) >> shr[4:0];
    end
  end

  always_comb begin
    case (cfg.src_fmt)
      FMT_F32: x = raw_sample[31] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
      FMT_S16: x = XW'($signed(raw_sample[15:0])) <<< (XFRAC - 15);
      FMT_U8:  x = XW'($signed({~raw_sample[7], raw_sample[6:0]})) <<< (XFRAC - 7);
      default: x = '0;
    endcase
    a_nxt = cfg.s16_path ? XW'($signed(raw_sample[15:0])) : x;
    b_nxt = cfg.s16_path ? cfg.gain16 : cfg.gain;
    p_nxt = a_r * b_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
    if (en[1]) begin
      p_r <= p_nxt;
    end
  end

  assign prod = p_r;

endmodule

// ===== design/asfg_back.sv =====
// Back stages: clamp the product, build integer results and find the leading one,
// then normalize and round to IEEE single. Depends on asfg_pkg.
module asfg_back #(
  parameter int GAIN_FRAC_BITS = asfg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic [2:0]                     en,
  input  logic signed [asfg_pkg::PW-1:0] prod,
  input  asfg_pkg::asfg_cfg_t            cfg,
  output logic [asfg_pkg::SAMPLE_W-1:0]  converted_sample
);
  import asfg_pkg::*;

  localparam int PFRAC = XFRAC + GAIN_FRAC_BITS;
  localparam int MW    = PFRAC + 1;
  localparam int LZW   = $clog2(MW);
  localparam logic signed [PW-1:0] BOUND   = PW'(64'd1 << PFRAC);
  localparam logic signed [PW-1:0] S16_MAX = PW'(32767);
  localparam logic signed [PW-1:0] S16_MIN = PW'(-32768);

  // stage 3
  logic signed [PW-1:0] pc_r, pc_nxt, t;
  logic [15:0]          r16_r, r16_nxt;
  // stage 4
  logic [PW-1:0]        absv;
  logic [MW-1:0]        mag, mag_r;
  logic [LZW-1:0]       lz, lz_r;
  logic                 neg, neg_r, zero_r, flt_r;
  logic [15:0]          m16, s16v;
  logic [PW-1:0]        usum;
  logic [8:0]           u9;
  logic [7:0]           u8v;
  logic [SAMPLE_W-1:0]  int_r, int_nxt;
  // stage 5
  logic [MW-1:0]        nm;
  logic [23:0]          q;
  logic                 guard, sticky, ovf;
  logic [24:0]          q25;
  logic [7:0]           expo;
  logic [22:0]          mant;
  logic [SAMPLE_W-1:0]  fbits, out_r, out_nxt;

  always_comb begin
    if (prod > BOUND) begin
      pc_nxt = BOUND;
    end else if (prod < -BOUND) begin
      pc_nxt = -BOUND;
    end else begin
      pc_nxt = prod;
    end
    t = prod >>> S16_SH;
    if (t > S16_MAX) begin
      r16_nxt = 16'h7FFF;
    end else if (t < S16_MIN) begin
      r16_nxt = 16'h8000;
    end else begin
      r16_nxt = t[15:0];
    end
  end

  always_comb begin
    neg  = pc_r[PW-1];
    absv = neg ? PW'(-pc_r) : PW'(pc_r);
    mag  = absv[MW-1:0];
    lz   = '0;
    for (int i = 0; i < MW; i++) begin
      if (mag[i]) lz = LZW'(MW - 1 - i);
    end
    m16  = mag[PFRAC -: 16];
    s16v = neg ? (16'd0 - m16) : m16;
    if (!neg && m16[15]) s16v = 16'h7FFF;
    usum = pc_r + BOUND;
    u9   = usum[PFRAC+1 -: 9];
    u8v  = u9[8] ? 8'hFF : u9[7:0];
    if (cfg.s16_path) begin
      int_nxt = {16'd0, r16_r};
    end else begin
      case (cfg.out_fmt)
        FMT_S16: int_nxt = {16'd0, s16v};
        FMT_U8:  int_nxt = {24'd0, u8v};
        default: int_nxt = '0;
      endcase
    end
  end

  // round to nearest even; a carry out of the mantissa bumps the exponent
  always_comb begin
    nm      = mag_r << lz_r;
    q       = nm[MW-1 -: 24];
    guard   = nm[MW-25];
    sticky  = |nm[MW-26:0];
    q25     = {1'b0, q} + 25'(guard && (sticky || q[0]));
    ovf     = q25[24];
    mant    = ovf ? 23'd0 : q25[22:0];
    expo    = 8'd127 - 8'(lz_r) + {7'd0, ovf};
    fbits   = zero_r ? '0 : {neg_r, expo, mant};
    out_nxt = flt_r ? fbits : int_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc_r  <= pc_nxt;
      r16_r <= r16_nxt;
    end
    if (en[1]) begin
      mag_r  <= mag;
      lz_r   <= lz;
      neg_r  <= neg;
      zero_r <= (pc_r == '0);
      flt_r  <= !cfg.s16_path && (cfg.out_fmt == FMT_F32);
      int_r  <= int_nxt;
    end
    if (en[2]) begin
      out_r <= out_nxt;
    end
  end

  assign converted_sample = out_r;

endmodule

// ===== design/audio_sample_format_gain_core.sv =====
// PCM sample format converter with volume: float32, s16 or u8 in and out.
// Channels: in_if takes one raw_sample per request, out_if returns one
// converted_sample per request, cfg_if writes source_format (index 0),
// output_format (index 1) and volume_gain (index 2, Q4.frac signed).
// cfg_if is always ready; write it only while no sample is in flight.
// Pipeline of five register stages: decode, multiply, clamp, integer
// encode with leading-one search, float normalize and round.
// Throughput: one sample per cycle while out_if does not stall; every stage
// holds a valid bit and fills whenever it is empty or the stage after it
// is ready, so a bubble ahead of a stalled result still takes new requests.
// Reset: formats return to s16, volume to 65536 (unity at 16 fraction bits); the pipeline empties.
// When out_if stalls, the last stage holds its result and the stall
// backs up stage by stage until in_if.ready drops.
// Depends on asfg_pkg, asfg_ifs, asfg_cfg_regs, asfg_front and asfg_back.
module audio_sample_format_gain_core #(
  parameter int GAIN_FRAC_BITS = asfg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  asfg_cfg_if.sink    cfg_if,
  asfg_in_if.sink     in_if,
  asfg_out_if.source  out_if
);
  import asfg_pkg::*;

  asfg_cfg_t         cfg;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] v_r, v_nxt, vin, en;
  logic signed [PW-1:0] prod;

  asfg_cfg_regs #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  asfg_front u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .raw_sample (in_if.raw_sample),
    .cfg        (cfg),
    .prod       (prod)
  );

  asfg_back #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_back (
    .clk              (clk),
    .en               (en[4:2]),
    .prod             (prod),
    .cfg              (cfg),
    .converted_sample (out_if.converted_sample)
  );

  // a stage loads when it is empty or its contents move on
  always_comb begin
    rdy[STAGES] = out_if.ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    vin   = {v_r[STAGES-2:0], in_if.valid};
    en    = rdy[STAGES-1:0] & vin;
    for (int i = 0; i < STAGES; i++) begin
      v_nxt[i] = rdy[i] ? vin[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_if.ready  = rdy[0];
  assign out_if.valid = v_r[STAGES-1];

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_if.ready) |-> !in_if.ready)
    else $error("request taken while the full pipeline is stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> v_r[0])
    else $error("accepted request did not enter the first stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STAGES-1] && !out_if.ready) |=> (v_r[STAGES-1] && $stable(out_if.converted_sample)))
    else $error("stalled result lost or changed");

endmodule
